>>> rtl/emt_pkg.sv
// Shared constants and types for the extended microsecond timebase.
`timescale 1ns / 1ps

package emt_pkg;

	localparam int PROFILER_SLOTS_DEF = 8;
	localparam int DIV_W = 17;
	localparam int LOW_W = 16;
	localparam int OVF_W = 32;
	localparam int TIME_W = LOW_W + OVF_W;
	localparam logic [DIV_W-1:0] DIVIDE_RESET = 17'd64;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_LAP = 2'd1;
	localparam logic [1:0] REQ_RESET = 2'd2;

	typedef struct packed {
		logic tick;
		logic clear;
	} cnt_ctrl_t;

endpackage

>>> rtl/extended_microsecond_timebase_top.sv
// Top level of the extended microsecond timebase: request control and lap arithmetic.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------
//  request   | req_type, profiler_index                | start high, busy low
//  result    | time_now, lap_elapsed                   | done, one cycle
//  config    | cfg_wr_data                             | cfg_wr_en
//
// A tick, a time reset or an unused request has its result beat appear the cycle
// after acceptance, and a new request is taken every cycle while busy is low.
// A lap passes lap_s1, where the lap start memory's registered read returns, then
// done_q; busy is high for the cycle between acceptance and the memory write-back.
// Reset clears the counters and the memory valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module extended_microsecond_timebase_top #(
	parameter int PROFILER_SLOTS = emt_pkg::PROFILER_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 req_type,
	input  logic [2:0]                 profiler_index,
	output logic                       done,
	output logic [emt_pkg::TIME_W-1:0] time_now,
	output logic [emt_pkg::LOW_W-1:0]  lap_elapsed,
	input  logic                       cfg_wr_en,
	input  logic [emt_pkg::DIV_W-1:0]  cfg_wr_data
);

	localparam int AW = (PROFILER_SLOTS > 1) ? $clog2(PROFILER_SLOTS) : 1;

	logic                      accept;
	logic                      in_range;
	logic [7:0]                idx_ext;
	logic [AW-1:0]             addr;
	emt_pkg::cnt_ctrl_t        cnt_ctrl;
	logic [emt_pkg::LOW_W-1:0] low_count;
	logic [emt_pkg::OVF_W-1:0] overflow_count;
	logic [emt_pkg::LOW_W-1:0] rd_data;
	logic [emt_pkg::LOW_W-1:0] base_q;
	logic                      lap_s1;
	logic                      hit_s1;
	logic [AW-1:0]             addr_s1;
	logic                      done_q;
	logic [emt_pkg::LOW_W-1:0] elapsed_q;
	logic                      wr_en;
	logic [emt_pkg::LOW_W-1:0] wr_data;
	logic [emt_pkg::LOW_W-1:0] elapsed;

	assign accept = start && !busy;
	assign busy = lap_s1;
	assign idx_ext = {5'd0, profiler_index};
	assign addr = idx_ext[AW-1:0];
	assign in_range = 32'(profiler_index) < PROFILER_SLOTS;

	assign cnt_ctrl.tick = accept && (req_type == emt_pkg::REQ_TICK);
	assign cnt_ctrl.clear = accept && (req_type == emt_pkg::REQ_RESET);

	emt_counter u_counter (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.ctrl           (cnt_ctrl),
		.low_count      (low_count),
		.overflow_count (overflow_count)
	);

	// Stored starts are kept relative to base_q, so a time reset only moves base_q.
	assign wr_en = lap_s1 && hit_s1;
	assign wr_data = low_count + base_q;
	assign elapsed = low_count - rd_data + base_q;

	emt_lap_ram #(
		.SLOTS (PROFILER_SLOTS),
		.AW    (AW)
	) u_lap_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && (req_type == emt_pkg::REQ_LAP) && in_range),
		.rd_addr (addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			lap_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			lap_s1 <= accept && (req_type == emt_pkg::REQ_LAP);
			done_q <= (accept && (req_type != emt_pkg::REQ_LAP)) || lap_s1;
			if (cnt_ctrl.clear) begin
				base_q <= base_q + low_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= in_range;
			addr_s1 <= addr;
		end
		elapsed_q <= wr_en ? elapsed : '0;
	end

	assign done = done_q;
	assign time_now = {overflow_count, low_count};
	assign lap_elapsed = elapsed_q;

endmodule

>>> rtl/emt_counter.sv
// Prescaler, 16-bit low count and 32-bit overflow count with the divider register.
`timescale 1ns / 1ps

module emt_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [emt_pkg::DIV_W-1:0]     cfg_wr_data,
	input  emt_pkg::cnt_ctrl_t            ctrl,
	output logic [emt_pkg::LOW_W-1:0]     low_count,
	output logic [emt_pkg::OVF_W-1:0]     overflow_count
);

	logic [emt_pkg::DIV_W-1:0] divide_q;
	logic [emt_pkg::LOW_W-1:0] presc_q;
	logic [emt_pkg::LOW_W-1:0] low_q;
	logic [emt_pkg::OVF_W-1:0] ovf_q;
	logic [emt_pkg::DIV_W-1:0] reload_full;
	logic [emt_pkg::LOW_W-1:0] reload;

	assign reload_full = divide_q - emt_pkg::DIV_W'(1);
	assign reload = reload_full[emt_pkg::LOW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divide_q <= emt_pkg::DIVIDE_RESET;
			presc_q <= '0;
			low_q <= '0;
			ovf_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				divide_q <= cfg_wr_data;
			end
			if (ctrl.clear) begin
				low_q <= '0;
				ovf_q <= '0;
			end else if (ctrl.tick) begin
				if (presc_q >= reload) begin
					presc_q <= '0;
					low_q <= low_q + emt_pkg::LOW_W'(1);
					if (&low_q) begin
						ovf_q <= ovf_q + emt_pkg::OVF_W'(1);
					end
				end else begin
					presc_q <= presc_q + emt_pkg::LOW_W'(1);
				end
			end
		end
	end

	assign low_count = low_q;
	assign overflow_count = ovf_q;

endmodule

>>> rtl/emt_lap_ram.sv
// Lap start memory with one registered read port, one write port and per-entry valid bits.
`timescale 1ns / 1ps

module emt_lap_ram #(
	parameter int SLOTS = emt_pkg::PROFILER_SLOTS_DEF,
	parameter int AW = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [emt_pkg::LOW_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [emt_pkg::LOW_W-1:0] wr_data
);

	logic [emt_pkg::LOW_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]          valid_q;
	logic [emt_pkg::LOW_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_q;

endmodule

>>> tb/tb_extended_microsecond_timebase_top.sv
// Self-checking testbench for the extended microsecond timebase with a built-in timebase predictor.
`timescale 1ns / 1ps

module tb_extended_microsecond_timebase_top;

	import emt_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot;
	} request_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [LOW_W-1:0] lap;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = REQ_TICK;
	logic [2:0] profiler_index = 3'd0;
	logic done;
	logic [TIME_W-1:0] time_now;
	logic [LOW_W-1:0] lap_elapsed;
	logic cfg_wr_en = 1'b0;
	logic [DIV_W-1:0] cfg_wr_data = '0;

	request_t request_q[$];
	reading_t expected_readings[$];
	int sender_idle_pct = 0;
	int faults = 0;
	int stall_cycles = 0;

	logic [DIV_W-1:0] tb_divide = DIVIDE_RESET;
	logic [LOW_W-1:0] tb_prescale = '0;
	logic [LOW_W-1:0] tb_low = '0;
	logic [OVF_W-1:0] tb_overflow = '0;
	logic [LOW_W-1:0] tb_lap_start [PROFILER_SLOTS_DEF];

	extended_microsecond_timebase_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.profiler_index(profiler_index),
		.done(done),
		.time_now(time_now),
		.lap_elapsed(lap_elapsed),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic advance_timebase(input request_t rq, output reading_t rd);
		logic [LOW_W-1:0] reload;
		logic [LOW_W-1:0] shift;
		rd.lap = '0;
		case (rq.kind)
			REQ_TICK: begin
				reload = LOW_W'(tb_divide - 1'b1);
				if (tb_prescale >= reload) begin
					tb_prescale = '0;
					tb_low = tb_low + 1'b1;
					if (tb_low == '0)
						tb_overflow = tb_overflow + 1'b1;
				end else begin
					tb_prescale = tb_prescale + 1'b1;
				end
			end
			REQ_LAP: begin
				if (int'(rq.slot) < PROFILER_SLOTS_DEF) begin
					rd.lap = tb_low - tb_lap_start[rq.slot];
					tb_lap_start[rq.slot] = tb_low;
				end
			end
			REQ_RESET: begin
				shift = tb_low;
				tb_low = '0;
				tb_overflow = '0;
				for (int i = 0; i < PROFILER_SLOTS_DEF; i++)
					tb_lap_start[i] = tb_lap_start[i] - shift;
			end
			default: begin
			end
		endcase
		rd.stamp = {tb_overflow, tb_low};
	endtask

	// Driver: predicts each accepted beat and presents the next pending request.
	always @(posedge clk) begin
		request_t rq;
		reading_t rd;
		if (cfg_wr_en)
			tb_divide = cfg_wr_data;
		if (start && !busy) begin
			rq.kind = req_type;
			rq.slot = profiler_index;
			advance_timebase(rq, rd);
			expected_readings.push_back(rd);
		end
		if (!start || !busy) begin
			if (arst_n && request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				rq = request_q.pop_front();
				start <= 1'b1;
				req_type <= rq.kind;
				profiler_index <= rq.slot;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string field, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		faults++;
		if (faults <= REPORT_LIMIT)
			$display("mismatch on %s: expected 0x%0h, actual 0x%0h", field, want, got);
	endtask

	// Monitor: every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		reading_t rd;
		if (arst_n && done) begin
			if (expected_readings.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("result beat with no expectation: time 0x%0h lap 0x%0h",
						time_now, lap_elapsed);
			end else begin
				rd = expected_readings.pop_front();
				if (time_now !== rd.stamp)
					report_mismatch("time_now", rd.stamp, time_now);
				if (lap_elapsed !== rd.lap)
					report_mismatch("lap_elapsed", TIME_W'(rd.lap), TIME_W'(lap_elapsed));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("extended_microsecond_timebase_top test failed");
				$finish;
			end
		end
	end

	function automatic request_t rand_request(input int tick_pct);
		request_t rq;
		int pick;
		rq.slot = 3'($urandom_range(7));
		if ($urandom_range(99) < tick_pct) begin
			rq.kind = REQ_TICK;
		end else begin
			pick = $urandom_range(99);
			if (pick < 75)
				rq.kind = REQ_LAP;
			else if (pick < 88)
				rq.kind = REQ_RESET;
			else
				rq.kind = REQ_UNUSED;
		end
		return rq;
	endfunction

	function automatic request_t make_request(input logic [1:0] kind, input logic [2:0] slot);
		request_t rq;
		rq.kind = kind;
		rq.slot = slot;
		return rq;
	endfunction

	task automatic settle();
		while (request_q.size() != 0 || start || expected_readings.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_divide(input logic [DIV_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input logic [DIV_W-1:0] value, input int idle_pct, input int count,
			input int tick_pct);
		write_divide(value);
		sender_idle_pct = idle_pct;
		repeat (count) request_q.push_back(rand_request(tick_pct));
		settle();
	endtask

	initial begin
		for (int i = 0; i < PROFILER_SLOTS_DEF; i++)
			tb_lap_start[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// The divider at its reset value before any write.
		sender_idle_pct = 0;
		repeat (100) request_q.push_back(rand_request(90));
		settle();

		write_divide(17'd1);
		request_q.push_back(make_request(REQ_LAP, 3'd0));
		repeat (3) request_q.push_back(make_request(REQ_TICK, 3'd0));
		request_q.push_back(make_request(REQ_LAP, 3'd7));
		request_q.push_back(make_request(REQ_LAP, 3'd7));
		request_q.push_back(make_request(REQ_TICK, 3'd2));
		request_q.push_back(make_request(REQ_LAP, 3'd0));
		request_q.push_back(make_request(REQ_RESET, 3'd1));
		request_q.push_back(make_request(REQ_LAP, 3'd7));
		request_q.push_back(make_request(REQ_LAP, 3'd0));
		request_q.push_back(make_request(REQ_UNUSED, 3'd5));
		request_q.push_back(make_request(REQ_TICK, 3'd6));
		request_q.push_back(make_request(REQ_LAP, 3'd4));
		request_q.push_back(make_request(REQ_RESET, 3'd7));
		request_q.push_back(make_request(REQ_RESET, 3'd0));
		request_q.push_back(make_request(REQ_LAP, 3'd2));
		repeat (3) request_q.push_back(make_request(REQ_TICK, 3'd5));
		request_q.push_back(make_request(REQ_LAP, 3'd7));
		request_q.push_back(make_request(REQ_UNUSED, 3'd2));
		request_q.push_back(make_request(REQ_LAP, 3'd1));
		request_q.push_back(make_request(REQ_LAP, 3'd6));
		settle();

		run_random(17'd3, 56, 90, 60);
		run_random(17'h10000, 0, 50, 80);
		// Lowering the divider while the prescaler is well past the new reload.
		run_random(17'd5, 27, 80, 60);
		run_random(17'd0, 56, 40, 70);
		run_random(17'h1FFFF, 0, 40, 70);
		run_random(17'd2, 27, 80, 60);
		run_random(17'd1, 56, 60, 50);
		run_random(17'd4, 0, 40, 60);

		settle();
		if (faults == 0)
			$display("extended_microsecond_timebase_top test passed");
		else
			$display("extended_microsecond_timebase_top test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/emt_pkg.sv
rtl/emt_counter.sv
rtl/emt_lap_ram.sv
rtl/extended_microsecond_timebase_top.sv
tb/tb_extended_microsecond_timebase_top.sv
